FILE: design/crc8fr_pkg.sv
// crc8fr_pkg: shared types, constants and the CRC-8 byte update for the
// crc8_frame_receiver block. No dependencies.
`timescale 1ns / 1ps

package crc8fr_pkg;

  localparam int unsigned HDR_LEN     = 2;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // register reset values
  localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND_RST = 8'h55;
  localparam logic [7:0] CRC_INIT_RST   = 8'hFF;
  localparam logic [7:0] CRC_XOROUT_RST = 8'h00;

  typedef enum logic [1:0] {
    REG_HDR_FIRST  = 2'd0,
    REG_HDR_SECOND = 2'd1,
    REG_CRC_INIT   = 2'd2,
    REG_CRC_XOROUT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_GOOD = 2'd1,
    EV_BAD  = 2'd2
  } frame_event_e;

  typedef struct packed {
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
    logic [7:0] crc_init;
    logic [7:0] crc_xorout;
  } cfg_t;

  // input register contents handed to the deframer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_stage_t;

  // reflected CRC-8, one byte folded in
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/crc8fr_if.sv
// crc8fr_if: valid/ready channel interfaces for received bytes and results.
// Depends on crc8fr_pkg.
`timescale 1ns / 1ps

interface crc8fr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         frame_event;
  logic                               data_valid;
  logic [crc8fr_pkg::PAYLOAD_W-1:0]   payload;
  logic [crc8fr_pkg::COUNT_W-1:0]     valid_frames;
  logic [crc8fr_pkg::COUNT_W-1:0]     crc_errors;

  modport source (output valid, output frame_event, output data_valid, output payload,
                  output valid_frames, output crc_errors, input ready);
  modport sink   (input valid, input frame_event, input data_valid, input payload,
                  input valid_frames, input crc_errors, output ready);
endinterface

FILE: design/crc8fr_cfg_regs.sv
// crc8fr_cfg_regs: APB register file for headers and CRC settings.
// Depends on crc8fr_pkg.
`timescale 1ns / 1ps

module crc8fr_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [crc8fr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [crc8fr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [crc8fr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready,
  output crc8fr_pkg::cfg_t                   cfg_o
);
  import crc8fr_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_sel;
  logic     wr_en;
  logic [7:0] rd_byte;

  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_first  <= HDR_FIRST_RST;
      cfg_q.hdr_second <= HDR_SECOND_RST;
      cfg_q.crc_init   <= CRC_INIT_RST;
      cfg_q.crc_xorout <= CRC_XOROUT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_HDR_FIRST:  cfg_q.hdr_first  <= pwdata[7:0];
        REG_HDR_SECOND: cfg_q.hdr_second <= pwdata[7:0];
        REG_CRC_INIT:   cfg_q.crc_init   <= pwdata[7:0];
        REG_CRC_XOROUT: cfg_q.crc_xorout <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HDR_FIRST:  rd_byte = cfg_q.hdr_first;
      REG_HDR_SECOND: rd_byte = cfg_q.hdr_second;
      REG_CRC_INIT:   rd_byte = cfg_q.crc_init;
      REG_CRC_XOROUT: rd_byte = cfg_q.crc_xorout;
      default:        rd_byte = 8'h00;
    endcase
  end

  assign prdata = CFG_DATA_W'(rd_byte);
  assign cfg_o  = cfg_q;

endmodule

FILE: design/crc8fr_in_stage.sv
// crc8fr_in_stage: input register for received bytes; holds one byte while
// the result side is stalled. Depends on crc8fr_pkg, crc8fr_if.
`timescale 1ns / 1ps

module crc8fr_in_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  crc8fr_rx_if.sink               rx,
  input  logic                    take_i,
  output crc8fr_pkg::in_stage_t   stage_o
);
  import crc8fr_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic       accept;

  assign rx.ready = !valid_q || take_i;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= rx.rx_byte;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

FILE: design/crc8fr_deframer.sv
// crc8fr_deframer: header hunt, payload gather, CRC check, counters and the
// result register. Depends on crc8fr_pkg, crc8fr_if.
`timescale 1ns / 1ps

module crc8fr_deframer #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  crc8fr_pkg::cfg_t       cfg_i,
  input  crc8fr_pkg::in_stage_t  stage_i,
  output logic                   take_o,
  crc8fr_res_if.source           res
);
  import crc8fr_pkg::*;

  localparam int unsigned   DataW  = PAYLOAD_BYTES * 8;
  localparam logic [POS_W-1:0] CrcPos = POS_W'(HDR_LEN + PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] HdrPos = POS_W'(HDR_LEN);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         crc_q, crc_d;
  logic [7:0]         gather_q [PAYLOAD_BYTES];
  logic [DataW-1:0]   gather_flat;
  logic [DataW-1:0]   held_q, held_d;
  logic               have_q, have_d;
  logic [COUNT_W-1:0] good_q, good_d;
  logic [COUNT_W-1:0] bad_q, bad_d;
  frame_event_e       event_q, event_d;
  logic               out_valid_q;
  logic               advance;
  logic [7:0]         b;
  logic [7:0]         crc_src;
  logic [7:0]         crc_next;

  assign advance = stage_i.valid && (!out_valid_q || res.ready);
  assign take_o  = advance;
  assign b       = stage_i.data;

  // a new frame starts its CRC from the configured seed
  assign crc_src  = (pos_q == '0) ? cfg_i.crc_init : crc_q;
  assign crc_next = crc8_byte(crc_src, b);

  for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_gather
    always_ff @(posedge clk_i) begin
      if (advance && (pos_q == POS_W'(HDR_LEN + k))) begin
        gather_q[k] <= b;
      end
    end
    assign gather_flat[8*k +: 8] = gather_q[k];
  end

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    held_d  = held_q;
    have_d  = have_q;
    good_d  = good_q;
    bad_d   = bad_q;
    event_d = EV_NONE;
    priority if (pos_q == '0) begin
      if (b == cfg_i.hdr_first) begin
        crc_d = crc_next;
        pos_d = POS_W'(1);
      end
    end else if (pos_q == POS_W'(1)) begin
      if (b == cfg_i.hdr_second) begin
        crc_d = crc_next;
        pos_d = HdrPos;
      end else if (b != cfg_i.hdr_first) begin
        pos_d = '0;
      end
      // repeated first header: keep waiting, CRC unchanged
    end else if (pos_q < CrcPos) begin
      crc_d = crc_next;
      pos_d = pos_q + POS_W'(1);
    end else if (pos_q == CrcPos) begin
      if (b == (crc_q ^ cfg_i.crc_xorout)) begin
        held_d  = gather_flat;
        have_d  = 1'b1;
        good_d  = (good_q != '1) ? good_q + COUNT_W'(1) : good_q;
        event_d = EV_GOOD;
      end else begin
        bad_d   = (bad_q != '1) ? bad_q + COUNT_W'(1) : bad_q;
        event_d = EV_BAD;
      end
      pos_d = '0;
    end else begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CRC_INIT_RST;
      held_q      <= '0;
      have_q      <= 1'b0;
      good_q      <= '0;
      bad_q       <= '0;
      event_q     <= EV_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        pos_q   <= pos_d;
        crc_q   <= crc_d;
        held_q  <= held_d;
        have_q  <= have_d;
        good_q  <= good_d;
        bad_q   <= bad_d;
        event_q <= event_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // state only moves when a result is loaded, so it doubles as the result
  assign res.valid        = out_valid_q;
  assign res.frame_event  = event_q;
  assign res.data_valid   = have_q;
  assign res.payload      = PAYLOAD_W'(held_q);
  assign res.valid_frames = good_q;
  assign res.crc_errors   = bad_q;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CrcPos)
    else $error("frame position beyond CRC byte");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (event_q != EV_NONE)) |-> (pos_q == '0))
    else $error("frame end without restarting the hunt");

  a_good_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (event_q == EV_GOOD)) |-> have_q)
    else $error("valid frame reported without held payload");

  a_counts_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ((good_q >= $past(good_q)) && (bad_q >= $past(bad_q))))
    else $error("frame counter went backward");
`endif

endmodule

FILE: design/crc8_frame_receiver.sv
// crc8_frame_receiver: top level of the CRC-8 checked frame receiver.
// Depends on crc8fr_pkg, crc8fr_if, crc8fr_cfg_regs, crc8fr_in_stage, crc8fr_deframer.
`timescale 1ns / 1ps

// Receives one byte per item, hunts for a two-byte header (a repeat of the
// first header byte keeps the hunt waiting for the second), gathers
// PAYLOAD_BYTES payload bytes and then checks a trailing reflected CRC-8
// (poly 0x8C, seed crc_init, crc_xorout applied before the compare) over
// header and payload. Every byte yields exactly one result item: the frame
// event (none / valid frame / checksum error), the data-valid flag, the last
// good payload (byte 0 in bits 7:0, zero above PAYLOAD_BYTES) and two
// saturating 32-bit counters. Throughput is one byte per clock unless the
// result stalls. Each byte is captured in the input register, then the
// CRC update and compare (one unrolled 8-bit CRC step) run into the result
// register. While a result waits at the output, one more byte is held in the
// input register. Registers (APB, 32-bit, at 4*index): 0 header_first
// (0xAA), 1 header_second (0x55), 2 crc_init (0xFF), 3 crc_xorout (0x00);
// write them only while the block is idle. There is no clearing pass.

module crc8_frame_receiver #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [crc8fr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [crc8fr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [crc8fr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready,
  crc8fr_rx_if.sink                          rx_i,
  crc8fr_res_if.source                       res_o
);
  import crc8fr_pkg::*;

  cfg_t      cfg;
  in_stage_t stage;
  logic      take;

  crc8fr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // byte capture; decouples the sender from a stalled result
  crc8fr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx      (rx_i),
    .take_i  (take),
    .stage_o (stage)
  );

  // hunt / gather / check and the result register
  crc8fr_deframer #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_deframer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .stage_i (stage),
    .take_o  (take),
    .res     (res_o)
  );

endmodule
